// ===== design/mpts_pkg.sv =====
// Shared constants and widths for the mid-price threshold signal block.
package mpts_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);

    localparam int PRICE_W = 32;
    localparam int QTY_W   = 24;
    localparam int QSUM_W  = 28;
    localparam int WSUM_W  = 64;
    localparam int PROD_W  = PRICE_W + QSUM_W;
    localparam int VALUE_W = 48;
    localparam int SIG_W   = 49;
    localparam int FRAC_W  = 16;
    localparam int DIVD_W  = WSUM_W + FRAC_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_SIZE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_QUANTITY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRADING_ENABLED  = 3'd4;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_SELL = 2'd1;
    localparam logic [1:0] SIDE_BUY  = 2'd2;

    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic done;
    } unit_stat_t;

endpackage

// ===== design/mid_price_threshold_signal.sv =====
// Top level of the mid-price threshold signal block.
//
// An order-book snapshot arrives on the input channel as a run of words, one
// depth layer per word, best layer first, layer_last set on the deepest one.
// A word is taken when in_valid is high and in_stall is low. For each of the
// first MAX_LEVELS layers the bit-serial multiplier forms the two price-quantity
// products one after the other, and the next word is taken only once both are
// done. Deeper layers are dropped without a multiply. On the last layer an
// 80-step restoring divider forms the Q.16 value. In weighted mode the quantity
// sum is first multiplied by the tick size. The next word can be taken in the
// cycle after the result word enters the output register. A snapshot gives at
// most one result word, and one whose best layer has no quantity gives none.
// The result sits in an output register until out_stall is low. While it waits
// the next snapshot is taken, and only its final step waits for the register.
// Reset restores the configuration defaults (tick size one), drops any partial
// snapshot and forgets the previous value, so the first result after reset
// reports an invalid signal. Configuration must be written only while idle;
// the block itself does not enforce this.
module mid_price_threshold_signal (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mpts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [31:0]                          bid_px,
    input  logic [23:0]                          bid_qty,
    input  logic [31:0]                          ask_px,
    input  logic [23:0]                          ask_qty,
    input  logic                                 layer_last,
    input  logic signed [31:0]                   current_position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [47:0]                          price_value,
    output logic signed [48:0]                   signal,
    output logic                                 signal_valid,
    output logic [1:0]                           order_side,
    output logic [31:0]                          order_price,
    output logic [23:0]                          order_size,
    output logic                                 order_live
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BID,
        ST_MUL_ASK,
        ST_CLOSE,
        ST_DEN_MUL,
        ST_DIVIDE,
        ST_SIGNAL,
        ST_ORDER
    } state_t;

    // Configuration registers.
    logic                             weighted_mode_reg;
    logic [47:0]                      signal_threshold_reg;
    logic [31:0]                      tick_size_reg;
    logic [23:0]                      order_quantity_reg;
    logic                             trading_enabled_reg;

    // Snapshot accumulation.
    state_t                           state_reg;
    logic [mpts_pkg::WSUM_W-1:0]      wsum_reg;
    logic [mpts_pkg::QSUM_W-1:0]      qsum_reg;
    logic [31:0]                      best_bid_reg;
    logic [31:0]                      best_ask_reg;
    logic                             best_empty_reg;
    logic [mpts_pkg::CNT_W-1:0]       layer_count_reg;
    logic [31:0]                      ask_px_reg;
    logic [23:0]                      ask_qty_reg;
    logic                             last_reg;
    logic signed [31:0]               position_reg;

    // Value history and signal.
    logic [47:0]                      value_reg;
    logic [47:0]                      prev_value_reg;
    logic                             prev_valid_reg;
    logic signed [48:0]               sig_reg;
    logic                             sig_valid_reg;

    // Output register.
    logic                             out_valid_reg;
    logic [47:0]                      out_value_reg;
    logic signed [48:0]               out_sig_reg;
    logic                             out_sig_valid_reg;
    logic [1:0]                       out_side_reg;
    logic [31:0]                      out_price_reg;
    logic [23:0]                      out_size_reg;
    logic                             out_live_reg;

    // Serial units.
    mpts_pkg::unit_ctrl_t             mul_ctrl_reg;
    mpts_pkg::unit_ctrl_t             div_ctrl_reg;
    mpts_pkg::unit_stat_t             mul_stat;
    mpts_pkg::unit_stat_t             div_stat;
    logic [31:0]                      mul_a_reg;
    logic [mpts_pkg::QSUM_W-1:0]      mul_b_reg;
    logic [mpts_pkg::PROD_W-1:0]      mul_prod;
    logic [mpts_pkg::WSUM_W-1:0]      div_num_reg;
    logic [mpts_pkg::PROD_W-1:0]      div_den_reg;
    logic [47:0]                      div_quot;

    logic                             in_accept;
    logic                             out_free;
    logic [31:0]                      tick_eff;
    logic [mpts_pkg::SIG_W-1:0]       sig_mag;
    logic                             sig_pos;
    logic                             sig_neg;
    logic                             pos_pos;
    logic                             pos_neg;
    logic                             raise;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign tick_eff  = (tick_size_reg == '0) ? 32'd1 : tick_size_reg;

    always_comb
    begin
        sig_pos = !sig_reg[mpts_pkg::SIG_W-1] && (sig_reg != '0);
        sig_neg = sig_reg[mpts_pkg::SIG_W-1];
        sig_mag = sig_neg ? (-sig_reg) : sig_reg;
        pos_pos = !position_reg[31] && (position_reg != '0);
        pos_neg = position_reg[31];
        // A signal of either sign trades only when the position is flat or on its side.
        raise   = sig_valid_reg && (sig_pos || sig_neg)
                  && (sig_mag >= {1'b0, signal_threshold_reg})
                  && !(sig_pos && pos_neg) && !(sig_neg && pos_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weighted_mode_reg    <= 1'b0;
            signal_threshold_reg <= '0;
            tick_size_reg        <= 32'd1;
            order_quantity_reg   <= '0;
            trading_enabled_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpts_pkg::REG_WEIGHTED_MODE:    weighted_mode_reg    <= cfg_data[0];
                mpts_pkg::REG_SIGNAL_THRESHOLD: signal_threshold_reg <= cfg_data[47:0];
                mpts_pkg::REG_TICK_SIZE:        tick_size_reg        <= cfg_data[31:0];
                mpts_pkg::REG_ORDER_QUANTITY:   order_quantity_reg   <= cfg_data[23:0];
                mpts_pkg::REG_TRADING_ENABLED:  trading_enabled_reg  <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            wsum_reg          <= '0;
            qsum_reg          <= '0;
            best_bid_reg      <= '0;
            best_ask_reg      <= '0;
            best_empty_reg    <= 1'b0;
            layer_count_reg   <= '0;
            ask_px_reg        <= '0;
            ask_qty_reg       <= '0;
            last_reg          <= 1'b0;
            position_reg      <= '0;
            value_reg         <= '0;
            prev_valid_reg    <= 1'b0;
            prev_value_reg    <= '0;
            sig_reg           <= '0;
            sig_valid_reg     <= 1'b0;
            mul_ctrl_reg      <= '0;
            div_ctrl_reg      <= '0;
            mul_a_reg         <= '0;
            mul_b_reg         <= '0;
            div_num_reg       <= '0;
            div_den_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_value_reg     <= '0;
            out_sig_reg       <= '0;
            out_sig_valid_reg <= 1'b0;
            out_side_reg      <= mpts_pkg::SIDE_NONE;
            out_price_reg     <= '0;
            out_size_reg      <= '0;
            out_live_reg      <= 1'b0;
        end
        else
        begin
            mul_ctrl_reg <= '0;
            div_ctrl_reg <= '0;
            // A new word enters the output register as the old one leaves.
            if ((state_reg == ST_ORDER) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        last_reg     <= layer_last;
                        position_reg <= current_position;
                        ask_px_reg   <= ask_px;
                        ask_qty_reg  <= ask_qty;
                        if (layer_count_reg < mpts_pkg::CNT_W'(mpts_pkg::MAX_LEVELS))
                        begin
                            if (layer_count_reg == '0)
                            begin
                                best_bid_reg   <= bid_px;
                                best_ask_reg   <= ask_px;
                                best_empty_reg <= (bid_qty == '0) && (ask_qty == '0);
                            end
                            qsum_reg <= qsum_reg
                                        + {4'b0, bid_qty} + {4'b0, ask_qty};
                            layer_count_reg    <= layer_count_reg + 1'b1;
                            mul_a_reg          <= bid_px;
                            mul_b_reg          <= {4'b0, bid_qty};
                            mul_ctrl_reg.start <= 1'b1;
                            state_reg          <= ST_MUL_BID;
                        end
                        else if (layer_last)
                        begin
                            state_reg <= ST_CLOSE;
                        end
                    end
                end
                ST_MUL_BID:
                begin
                    if (mul_stat.done)
                    begin
                        wsum_reg           <= wsum_reg + {4'b0, mul_prod};
                        mul_a_reg          <= ask_px_reg;
                        mul_b_reg          <= {4'b0, ask_qty_reg};
                        mul_ctrl_reg.start <= 1'b1;
                        state_reg          <= ST_MUL_ASK;
                    end
                end
                ST_MUL_ASK:
                begin
                    if (mul_stat.done)
                    begin
                        wsum_reg  <= wsum_reg + {4'b0, mul_prod};
                        state_reg <= last_reg ? ST_CLOSE : ST_IDLE;
                    end
                end
                ST_CLOSE:
                begin
                    if (best_empty_reg)
                    begin
                        // Empty best layer: drop the snapshot, keep the history.
                        wsum_reg        <= '0;
                        qsum_reg        <= '0;
                        best_bid_reg    <= '0;
                        best_ask_reg    <= '0;
                        best_empty_reg  <= 1'b0;
                        layer_count_reg <= '0;
                        state_reg       <= ST_IDLE;
                    end
                    else if (weighted_mode_reg)
                    begin
                        mul_a_reg          <= tick_eff;
                        mul_b_reg          <= qsum_reg;
                        mul_ctrl_reg.start <= 1'b1;
                        state_reg          <= ST_DEN_MUL;
                    end
                    else
                    begin
                        div_num_reg <= {31'b0, ({1'b0, best_bid_reg} + {1'b0, best_ask_reg})};
                        div_den_reg <= {27'b0, tick_eff, 1'b0};
                        div_ctrl_reg.start <= 1'b1;
                        state_reg          <= ST_DIVIDE;
                    end
                end
                ST_DEN_MUL:
                begin
                    if (mul_stat.done)
                    begin
                        div_num_reg        <= wsum_reg;
                        div_den_reg        <= mul_prod;
                        div_ctrl_reg.start <= 1'b1;
                        state_reg          <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        value_reg <= div_quot;
                        state_reg <= ST_SIGNAL;
                    end
                end
                ST_SIGNAL:
                begin
                    sig_valid_reg  <= prev_valid_reg;
                    sig_reg        <= prev_valid_reg
                                      ? ($signed({1'b0, value_reg}) - $signed({1'b0, prev_value_reg}))
                                      : '0;
                    prev_value_reg <= value_reg;
                    prev_valid_reg <= 1'b1;
                    state_reg      <= ST_ORDER;
                end
                ST_ORDER:
                begin
                    if (out_free)
                    begin
                        out_value_reg     <= value_reg;
                        out_sig_reg       <= sig_reg;
                        out_sig_valid_reg <= sig_valid_reg;
                        out_side_reg      <= raise ? (sig_pos ? mpts_pkg::SIDE_SELL
                                                              : mpts_pkg::SIDE_BUY)
                                                   : mpts_pkg::SIDE_NONE;
                        out_price_reg     <= raise ? (sig_pos ? best_bid_reg : best_ask_reg)
                                                   : '0;
                        out_size_reg      <= raise ? order_quantity_reg : '0;
                        out_live_reg      <= raise && trading_enabled_reg;
                        wsum_reg          <= '0;
                        qsum_reg          <= '0;
                        best_bid_reg      <= '0;
                        best_ask_reg      <= '0;
                        best_empty_reg    <= 1'b0;
                        layer_count_reg   <= '0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    mpts_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl_reg),
        .mcand   (mul_a_reg),
        .mplier  (mul_b_reg),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    mpts_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl_reg),
        .num      (div_num_reg),
        .den      (div_den_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign out_valid    = out_valid_reg;
    assign price_value  = out_value_reg;
    assign signal       = out_sig_reg;
    assign signal_valid = out_sig_valid_reg;
    assign order_side   = out_side_reg;
    assign order_price  = out_price_reg;
    assign order_size   = out_size_reg;
    assign order_live   = out_live_reg;

endmodule

// ===== design/mpts_serial_mul.sv =====
// Shift-and-add multiplier that takes one multiplier bit per cycle.
module mpts_serial_mul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mpts_pkg::unit_ctrl_t                   ctrl,
    input  logic [mpts_pkg::PRICE_W-1:0]           mcand,
    input  logic [mpts_pkg::QSUM_W-1:0]            mplier,
    output mpts_pkg::unit_stat_t                   stat,
    output logic [mpts_pkg::PROD_W-1:0]            product
);

    localparam int CW = $clog2(mpts_pkg::QSUM_W);
    localparam logic [CW-1:0] LAST_BIT = CW'(mpts_pkg::QSUM_W - 1);

    logic [mpts_pkg::PROD_W-1:0] mcand_reg;
    logic [mpts_pkg::QSUM_W-1:0] mplier_reg;
    logic [mpts_pkg::PROD_W-1:0] acc_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [mpts_pkg::PROD_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mcand_reg  <= {{(mpts_pkg::PROD_W - mpts_pkg::PRICE_W){1'b0}}, mcand};
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[mpts_pkg::PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[mpts_pkg::QSUM_W-1:1]};
        end
    end

    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

// ===== design/mpts_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, giving floor(num * 2^16 / den) saturated.
module mpts_serial_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mpts_pkg::unit_ctrl_t                   ctrl,
    input  logic [mpts_pkg::WSUM_W-1:0]            num,
    input  logic [mpts_pkg::PROD_W-1:0]            den,
    output mpts_pkg::unit_stat_t                   stat,
    output logic [mpts_pkg::VALUE_W-1:0]           quotient
);

    localparam int CW = $clog2(mpts_pkg::DIVD_W);
    localparam logic [CW-1:0] LAST_BIT = CW'(mpts_pkg::DIVD_W - 1);

    logic [mpts_pkg::DIVD_W-1:0]  dvd_reg;
    logic [mpts_pkg::PROD_W-1:0]  den_reg;
    logic [mpts_pkg::PROD_W-1:0]  rem_reg;
    logic [mpts_pkg::VALUE_W-1:0] q_reg;
    logic                         sat_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [mpts_pkg::VALUE_W-1:0] value_reg;

    logic [mpts_pkg::PROD_W:0]    rem_sh;
    logic [mpts_pkg::PROD_W:0]    diff;
    logic                         fits;
    logic [mpts_pkg::PROD_W-1:0]  rem_next;
    logic [mpts_pkg::VALUE_W-1:0] q_next;
    logic                         sat_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[mpts_pkg::DIVD_W-1]};
        diff     = rem_sh - {1'b0, den_reg};
        fits     = !diff[mpts_pkg::PROD_W];
        rem_next = fits ? diff[mpts_pkg::PROD_W-1:0] : rem_sh[mpts_pkg::PROD_W-1:0];
        q_next   = {q_reg[mpts_pkg::VALUE_W-2:0], fits};
        sat_next = sat_reg | q_reg[mpts_pkg::VALUE_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            dvd_reg <= {num, {mpts_pkg::FRAC_W{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[mpts_pkg::DIVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= q_next;
            sat_reg <= sat_next;
            if (cnt_reg == LAST_BIT)
            begin
                value_reg <= sat_next ? {mpts_pkg::VALUE_W{1'b1}} : q_next;
            end
        end
    end

    assign stat.done = done_reg;
    assign quotient  = value_reg;

endmodule

// ===== design/mpts_checker.sv =====
// Port-level checks for the mid-price threshold signal block, bound to the top level.
module mpts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [47:0]        price_value,
    input logic signed [48:0] signal,
    input logic               signal_valid,
    input logic [1:0]         order_side,
    input logic [31:0]        order_price,
    input logic [23:0]        order_size,
    input logic               order_live
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(price_value) && $stable(signal))
        else $error("result word changed while stalled");

    a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (order_side == mpts_pkg::SIDE_NONE) || (order_side == mpts_pkg::SIDE_SELL)
                      || (order_side == mpts_pkg::SIDE_BUY))
        else $error("illegal order side");

    a_no_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (order_side == mpts_pkg::SIDE_NONE)
            |-> (order_price == '0) && (order_size == '0) && !order_live)
        else $error("order fields set without an order");

    a_first_signal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !signal_valid |-> (signal == '0) && (order_side == mpts_pkg::SIDE_NONE))
        else $error("invalid signal carried a value or an order");

    a_side_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (order_side == mpts_pkg::SIDE_SELL) |-> !signal[48] && (signal != '0))
        else $error("sell order without a positive signal");

endmodule

bind mid_price_threshold_signal mpts_checker u_mpts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .price_value  (price_value),
    .signal       (signal),
    .signal_valid (signal_valid),
    .order_side   (order_side),
    .order_price  (order_price),
    .order_size   (order_size),
    .order_live   (order_live)
);
